// ----- rtl/dq_pkg.sv -----
// Package for the double-ended queue: sizes, operation codes and the control
// bundle broadcast along the storage chain. No dependencies.
package dq_pkg;

    localparam int DEPTH     = 1024;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int LEAVES    = 1 << PTR_W;
    localparam int WORD_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int CNT_OUT_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REM_HEAD = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE  = 2'd3;

    typedef struct packed {
        logic              shift_right;
        logic              shift_left;
        logic              write_tail;
        logic [PTR_W-1:0]  fill_idx;
        logic [PTR_W-1:0]  last_idx;
        logic [WORD_W-1:0] din;
    } dq_ctrl_t;

endpackage

// ----- rtl/double_ended_queue_with_reverse.sv -----
// Top level of the double-ended queue: control, result register, the cell
// chain and the tail read tree. Depends on dq_pkg, dq_cell, dq_tree.
//
//  channel  dir  signals                          contents
//  s_       in   s_tvalid s_tready s_tdata s_tuser  value; func
//  m_       out  m_tvalid m_tready m_tdata m_tuser  removed_value, count; ok
//
// Inserts, reverse and head removal in normal orientation or from an empty
// queue put their result straight into the output register.
// A head removal from a non-empty queue while reversed reads the last occupied
// cell through the registered OR tree, waiting in ST_WAIT while it counts down.
// Reset (aresetn low, synchronous) empties the queue; cell words are not cleared.
// A result waits in the output register; a new item is taken once it is free
// or being transferred in the same cycle.
module double_ended_queue_with_reverse
    import dq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] removed_value, [42:32] count, rest zero
    output logic [0:0]  m_tuser    // [0] ok
);

    localparam int          WAIT_W  = $clog2(PTR_W + 1);
    localparam logic        ST_IDLE = 1'b0;
    localparam logic        ST_WAIT = 1'b1;

    logic                state_reg, state_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                rev_reg, rev_next;
    logic                m_valid_reg, m_valid_next;
    logic                ok_reg, ok_next;
    logic [WORD_W-1:0]   rv_reg, rv_next;

    dq_ctrl_t            ctrl;
    logic [WORD_W-1:0]   cell_word [DEPTH];
    logic [WORD_W-1:0]   leaf      [LEAVES];
    logic [WORD_W-1:0]   tail_word;
    logic                accept;
    logic [FUNC_W-1:0]   func;
    logic                at_front;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser;
    assign at_front = (func == FUNC_INS_HEAD) == !rev_reg;

    always_comb begin
        ctrl             = '0;
        ctrl.din         = s_tdata;
        ctrl.fill_idx    = count_reg[PTR_W-1:0];
        ctrl.last_idx    = PTR_W'(count_reg - COUNT_W'(1));
        state_next       = state_reg;
        wait_next        = wait_reg;
        count_next       = count_reg;
        rev_next         = rev_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        ok_next          = ok_reg;
        rv_next          = rv_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            ok_next      = 1'b0;
            rv_next      = '0;
            case (func)
                FUNC_INS_HEAD, FUNC_INS_TAIL: begin
                    if (count_reg < COUNT_W'(DEPTH)) begin
                        ctrl.shift_right = at_front;
                        ctrl.write_tail  = !at_front;
                        count_next       = count_reg + COUNT_W'(1);
                        ok_next          = 1'b1;
                    end
                end
                FUNC_REM_HEAD: begin
                    if (count_reg != '0) begin
                        if (!rev_reg) begin
                            ctrl.shift_left = 1'b1;
                            rv_next         = cell_word[0];
                            count_next      = count_reg - COUNT_W'(1);
                            ok_next         = 1'b1;
                        end else begin
                            // hold the result until the tree has the tail word
                            m_valid_next = 1'b0;
                            state_next   = ST_WAIT;
                            wait_next    = WAIT_W'(PTR_W);
                        end
                    end
                end
                default: begin
                    rev_next = !rev_reg;
                    ok_next  = 1'b1;
                end
            endcase
        end else if (state_reg == ST_WAIT) begin
            if (wait_reg != '0) begin
                wait_next = wait_reg - WAIT_W'(1);
            end else if (!m_valid_reg) begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                ok_next      = 1'b1;
                rv_next      = tail_word;
                count_next   = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            count_reg   <= count_next;
            rev_reg     <= rev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg <= ok_next;
        rv_reg <= rv_next;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        if (i == 0) begin : g_first
            assign left_word = ctrl.din;
        end else begin : g_mid_l
            assign left_word = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = cell_word[i+1];
        end
        dq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .idx        (PTR_W'(i)),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i]),
            .tap        (leaf[i])
        );
    end

    for (genvar j = DEPTH; j < LEAVES; j++) begin : g_pad
        assign leaf[j] = '0;
    end

    dq_tree u_tree (
        .aclk (aclk),
        .leaf (leaf),
        .root (tail_word)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {5'd0, CNT_OUT_W'(count_reg), rv_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_wait_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) |-> !s_tready)
        else $error("input taken during tail read");

    a_full_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (count_reg == COUNT_W'(DEPTH)) &&
         ((func == FUNC_INS_HEAD) || (func == FUNC_INS_TAIL)))
        |=> (count_reg == $past(count_reg)) && !ok_reg)
        else $error("insert into full queue changed the count");

    a_front_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (func == FUNC_REM_HEAD) && (count_reg != '0) && !rev_reg)
        |=> (count_reg == $past(count_reg) - COUNT_W'(1)) && m_valid_reg)
        else $error("front removal did not shrink the queue");

    a_wait_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT) && (wait_reg != '0) |=> count_reg == $past(count_reg))
        else $error("count moved during tail read");

endmodule

// ----- rtl/dq_cell.sv -----
// One storage cell of the queue chain: holds a word, shifts with its
// neighbors, takes a tail write at its own index. Depends on dq_pkg.
module dq_cell
    import dq_pkg::*;
(
    input  logic              aclk,
    input  dq_ctrl_t          ctrl,
    input  logic [PTR_W-1:0]  idx,
    input  logic [WORD_W-1:0] left_word,
    input  logic [WORD_W-1:0] right_word,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] tap
);

    logic [WORD_W-1:0] word_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift_right) begin
            word_reg <= left_word;
        end else if (ctrl.shift_left) begin
            word_reg <= right_word;
        end else if (ctrl.write_tail && (idx == ctrl.fill_idx)) begin
            word_reg <= ctrl.din;
        end
    end

    assign word = word_reg;
    // drive the word into the reduction tree only from the last occupied cell
    assign tap  = (idx == ctrl.last_idx) ? word_reg : '0;

endmodule

// ----- rtl/dq_tree.sv -----
// Registered OR tree that collects the one selected cell tap. Depends on dq_pkg.
module dq_tree
    import dq_pkg::*;
(
    input  logic              aclk,
    input  logic [WORD_W-1:0] leaf [LEAVES],
    output logic [WORD_W-1:0] root
);

    logic [WORD_W-1:0] node_reg [1:LEAVES-1];

    for (genvar i = 1; i < LEAVES; i++) begin : g_node
        if (2 * i >= LEAVES) begin : g_leaf
            always_ff @(posedge aclk) begin
                node_reg[i] <= leaf[2*i-LEAVES] | leaf[2*i+1-LEAVES];
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                node_reg[i] <= node_reg[2*i] | node_reg[2*i+1];
            end
        end
    end

    assign root = node_reg[1];

endmodule

// ----- sim/tb_top.sv -----
// Testbench for double_ended_queue_with_reverse: a queued driver, a ready toggler, an in-line
// ring-buffer predictor and a result checker on the stream ports.
// Depends on dq_pkg and the double_ended_queue_with_reverse RTL.
module tb_top
    import dq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE       = PTR_W + 10;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [WORD_W-1:0] word;
        bit                wait_empty;
    } dq_op_t;

    typedef struct {
        logic                 ok;
        logic [WORD_W-1:0]    taken;
        logic [CNT_OUT_W-1:0] count;
    } dq_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    dq_op_t     pending_ops[$];
    dq_result_t predicted[$];
    int         err_count    = 0;
    int         total_ops    = 0;
    int         sent_n       = 0;
    int         done_n       = 0;
    int         quiet_cycles = 0;
    logic [1:0] idle_stage   = 2'd0;

    // predictor state: ring storage, pointers, occupancy and orientation
    logic [WORD_W-1:0] ring_mem [DEPTH];
    int                front_pos = 0;
    int                back_pos  = 0;
    int                held      = 0;
    bit                flipped   = 1'b0;

    double_ended_queue_with_reverse dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic dq_result_t apply_op(input logic [FUNC_W-1:0] op,
                                            input logic [WORD_W-1:0] word);
        dq_result_t r;
        bit         at_front;
        r.ok    = 1'b0;
        r.taken = '0;
        case (op)
            FUNC_INS_HEAD, FUNC_INS_TAIL: begin
                if (held < DEPTH) begin
                    // the logical head sits at the physical back while flipped
                    at_front = ((op == FUNC_INS_HEAD) == !flipped);
                    if (at_front) begin
                        front_pos = (front_pos + DEPTH - 1) % DEPTH;
                        ring_mem[PTR_W'(front_pos)] = word;
                    end else begin
                        ring_mem[PTR_W'(back_pos)] = word;
                        back_pos = (back_pos + 1) % DEPTH;
                    end
                    held++;
                    r.ok = 1'b1;
                end
            end
            FUNC_REM_HEAD: begin
                if (held > 0) begin
                    if (!flipped) begin
                        r.taken   = ring_mem[PTR_W'(front_pos)];
                        front_pos = (front_pos + 1) % DEPTH;
                    end else begin
                        back_pos = (back_pos + DEPTH - 1) % DEPTH;
                        r.taken  = ring_mem[PTR_W'(back_pos)];
                    end
                    held--;
                    r.ok = 1'b1;
                end
            end
            FUNC_REVERSE: begin
                flipped = !flipped;
                r.ok    = 1'b1;
            end
            default: ;
        endcase
        r.count = CNT_OUT_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic queue_op(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word,
                            input bit wait_empty = 1'b0);
        dq_op_t o;
        o.op         = op;
        o.word       = word;
        o.wait_empty = wait_empty;
        pending_ops.push_back(o);
    endtask

    function automatic logic [FUNC_W-1:0] pick_insert();
        return ($urandom_range(1) != 0) ? FUNC_INS_HEAD : FUNC_INS_TAIL;
    endfunction

    // driver: present the next pending operation, honoring sender idling
    always @(posedge aclk) begin : drive
        dq_op_t nxt;
        int     tx_idle;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) sent_n++;
            if (m_tvalid && m_tready) done_n++;
            if (sent_n * 3 < total_ops) begin
                tx_idle = 12;
                idle_stage <= 2'd0;
            end else if (sent_n * 3 < total_ops * 2) begin
                tx_idle = 57;
                idle_stage <= 2'd1;
            end else begin
                tx_idle = 0;
                idle_stage <= 2'd2;
            end
            if (!s_tvalid || s_tready) begin
                // hold a marked operation until every prior result has been seen
                if (pending_ops.size() != 0 &&
                    !(pending_ops[0].wait_empty && sent_n != done_n) &&
                    $urandom_range(99) >= tx_idle) begin
                    nxt = pending_ops.pop_front();
                    s_tuser  <= nxt.op;
                    s_tdata  <= nxt.word;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            case (idle_stage)
                2'd0:    m_tready <= ($urandom_range(99) >= 57);
                2'd1:    m_tready <= ($urandom_range(99) >= 12);
                default: m_tready <= 1'b1;
            endcase
    end

    // monitor: predict on each input transfer, check on each result transfer
    always @(posedge aclk) begin : monitor
        dq_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predicted.push_back(apply_op(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (predicted.size() == 0) begin
                    report_mismatch("result with no operation outstanding");
                end else begin
                    want = predicted.pop_front();
                    if (m_tuser[0] !== want.ok)
                        report_mismatch($sformatf("ok %b, want %b", m_tuser[0], want.ok));
                    if (m_tdata[31:0] !== want.taken)
                        report_mismatch($sformatf("removed_value %h, want %h",
                                                  m_tdata[31:0], want.taken));
                    if (m_tdata[42:32] !== want.count)
                        report_mismatch($sformatf("count %0d, want %0d",
                                                  m_tdata[42:32], want.count));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("double_ended_queue_with_reverse verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                n;
        int                k;
        int                run_len;
        int                mode;
        int                roll;
        logic [FUNC_W-1:0] op;

        // directed: empty cases, single-word reverse, extremes, both orientations
        queue_op(FUNC_REM_HEAD, 32'hDEAD_BEEF);
        queue_op(FUNC_REVERSE,  32'h0);
        queue_op(FUNC_REVERSE,  32'hFFFF_FFFF);
        queue_op(FUNC_INS_HEAD, 32'h7FFF_FFFF);
        queue_op(FUNC_REVERSE,  32'h0);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_INS_TAIL, 32'h8000_0000);
        queue_op(FUNC_INS_HEAD, 32'hFFFF_FFFF);
        queue_op(FUNC_INS_TAIL, 32'h0000_0000);
        queue_op(FUNC_INS_HEAD, 32'h5555_5555);
        queue_op(FUNC_INS_TAIL, 32'hAAAA_AAAA);
        queue_op(FUNC_REVERSE,  32'h0);
        queue_op(FUNC_INS_HEAD, 32'h0000_0001);
        queue_op(FUNC_INS_TAIL, 32'h1234_5678);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_REVERSE,  32'h0);
        for (k = 0; k < 6; k++)
            queue_op(FUNC_REM_HEAD, 32'h0);

        // fill past capacity, then remove across the full boundary
        queue_op(pick_insert(), $urandom(), 1'b1);
        for (k = 0; k < 1029; k++) begin
            if (k % 97 == 50)
                queue_op(FUNC_REVERSE, $urandom());
            queue_op(pick_insert(), $urandom());
        end
        queue_op(FUNC_REVERSE, 32'h0);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_INS_HEAD, $urandom());
        queue_op(FUNC_INS_TAIL, $urandom());
        queue_op(FUNC_REVERSE, 32'h0);
        queue_op(FUNC_REM_HEAD, 32'h0);
        queue_op(FUNC_INS_TAIL, $urandom());
        queue_op(FUNC_INS_HEAD, $urandom());

        // random bursts biased toward filling, draining or mixing
        n = 0;
        while (n < RANDOM_ITEMS) begin
            mode    = $urandom_range(2);
            run_len = $urandom_range(60, 10);
            for (k = 0; k < run_len; k++) begin
                roll = $urandom_range(99);
                if (roll < 8)
                    op = FUNC_REVERSE;
                else if (mode == 0)
                    op = (roll < 85) ? pick_insert() : FUNC_REM_HEAD;
                else if (mode == 1)
                    op = (roll < 25) ? pick_insert() : FUNC_REM_HEAD;
                else
                    op = (roll < 54) ? pick_insert() : FUNC_REM_HEAD;
                queue_op(op, $urandom(), (n == 0) || ($urandom_range(199) == 0));
                n++;
            end
        end
        total_ops = pending_ops.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid) @(negedge aclk);
        while (predicted.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        if (err_count == 0 && predicted.size() == 0)
            $display("double_ended_queue_with_reverse verification clean");
        else
            $display("double_ended_queue_with_reverse verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/dq_tree.sv
rtl/double_ended_queue_with_reverse.sv
sim/tb_top.sv
